// File: rtl/dmhq_pkg.sv
// ----------------------------------------------------------------------------
// dmhq_pkg
// shared types and constants of the d-ary min-heap queue
// ----------------------------------------------------------------------------
package dmhq_pkg;

  localparam int ARITY    = 4;
  localparam int CAPACITY = 4096;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int ENTRY_W  = 16 + 32 + 32 + 16;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [15:0] node;
    logic [31:0] key;
    logic [31:0] cost;
    logic [15:0] parent;
  } entry_t;

  // memory port bundle
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } mem_req_t;

endpackage

// File: rtl/dmhq_ram.sv
// ----------------------------------------------------------------------------
// dmhq_ram
// one-write one-read heap storage, registered read data
// ----------------------------------------------------------------------------
module dmhq_ram (
  input  logic                 clk,
  input  dmhq_pkg::mem_req_t   req,
  output dmhq_pkg::entry_t     rd_data
);

  dmhq_pkg::entry_t mem [dmhq_pkg::CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
  end

  // read port
  always_ff @(posedge clk) begin
    if (req.rd_en) rd_data <= mem[req.rd_addr];
  end

endmodule

// File: rtl/dmhq_ctrl.sv
// ----------------------------------------------------------------------------
// dmhq_ctrl
// sift-up and sift-down sequencer over the heap memory
// ----------------------------------------------------------------------------
module dmhq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_mode,
  input  dmhq_pkg::entry_t           in_entry,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [1:0]                 res_status,
  output dmhq_pkg::entry_t           res_entry,
  output logic [dmhq_pkg::CNT_W-1:0] res_count,
  output dmhq_pkg::mem_req_t         mreq,
  input  dmhq_pkg::entry_t           mrd
);

  localparam int AW = dmhq_pkg::ADDR_W;
  localparam int CW = dmhq_pkg::CNT_W;
  localparam int KW = $clog2(dmhq_pkg::ARITY + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_UPRD   = 9'b000000010,
    S_UPCMP  = 9'b000000100,
    S_POPRD  = 9'b000001000,
    S_LASTRD = 9'b000010000,
    S_LASTW  = 9'b000100000,
    S_CHRD   = 9'b001000000,
    S_CHCMP  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  dmhq_pkg::entry_t  moving;          // entry being sifted
  logic [AW-1:0]     pos;             // hole position
  logic [AW-1:0]     up;              // parent of hole
  logic [CW+2:0]     first;           // first child, wide to avoid wrap
  logic [KW-1:0]     ch;              // child offset being read
  logic [KW-1:0]     nch;             // children present
  logic              best_vld;
  logic [AW-1:0]     best_addr;
  dmhq_pkg::entry_t  best;

  logic [CW+2:0]     first_calc;
  logic [CW+2:0]     remain;

  // best child so far, folded with the child whose data arrives this cycle
  logic              take;
  logic              cand_vld;
  dmhq_pkg::entry_t  cand;
  logic [AW-1:0]     cand_addr;
  logic              sink_move;

  assign in_ready = (state == S_IDLE) && !res_valid;
  assign first_calc = (CW+3)'(pos) * (CW+3)'(dmhq_pkg::ARITY) + (CW+3)'(1);
  assign remain = (CW+3)'(count) - first_calc;

  assign take      = (ch != '0) && (!best_vld || mrd.key < best.key);
  assign cand_vld  = best_vld || (ch != '0);
  assign cand      = take ? mrd : best;
  assign cand_addr = take ? AW'(first + (CW+3)'(ch) - (CW+3)'(1)) : best_addr;
  assign sink_move = cand_vld && (cand.key < moving.key);

  // memory request
  always_comb begin
    mreq = '0;
    mreq.wr_data = moving;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready && in_mode && count != '0) begin
          mreq.rd_en = 1'b1;
          mreq.rd_addr = '0;
        end
      end
      S_UPRD: begin
        mreq.rd_en = 1'b1;
        mreq.rd_addr = up;
      end
      S_UPCMP: begin
        mreq.wr_en = 1'b1;
        mreq.wr_addr = pos;
        if (pos != '0 && moving.key < mrd.key) mreq.wr_data = mrd;
        else mreq.wr_data = moving;
      end
      S_POPRD: begin
        mreq.rd_en = 1'b1;
        mreq.rd_addr = AW'(count - CW'(1));
      end
      S_CHRD: begin
        mreq.rd_en = 1'b1;
        mreq.rd_addr = AW'(first + (CW+3)'(ch));
      end
      S_CHCMP: begin
        if (ch == nch) begin
          mreq.wr_en = 1'b1;
          mreq.wr_addr = pos;
          mreq.wr_data = sink_move ? cand : moving;
        end else begin
          mreq.rd_en = 1'b1;
          mreq.rd_addr = AW'(first + (CW+3)'(ch));
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            res_entry <= '0;
            if (!in_mode) begin
              if (count >= CW'(dmhq_pkg::CAPACITY)) begin
                res_status <= dmhq_pkg::ST_FULL;
                res_count <= count;
                res_valid <= 1'b1;
              end else begin
                res_status <= dmhq_pkg::ST_OK;
                moving <= in_entry;
                pos <= AW'(count);
                up <= AW'((count - CW'(1)) / CW'(dmhq_pkg::ARITY));
                count <= count + CW'(1);
                state <= S_UPRD;
              end
            end else if (count == '0) begin
              res_status <= dmhq_pkg::ST_EMPTY;
              res_count <= count;
              res_valid <= 1'b1;
            end else begin
              res_status <= dmhq_pkg::ST_OK;
              state <= S_POPRD;
            end
          end
        end
        S_UPRD: state <= S_UPCMP;
        S_UPCMP: begin
          if (pos != '0 && moving.key < mrd.key) begin
            pos <= up;
            up <= AW'((up - AW'(1)) / AW'(dmhq_pkg::ARITY));
            state <= S_UPRD;
          end else begin
            state <= S_OUT;
          end
        end
        S_POPRD: begin
          res_entry <= mrd;
          count <= count - CW'(1);
          state <= S_LASTRD;
        end
        S_LASTRD: begin
          moving <= mrd;
          pos <= '0;
          state <= S_LASTW;
        end
        S_LASTW: begin
          // next level setup
          first <= first_calc;
          ch <= '0;
          best_vld <= 1'b0;
          if (first_calc >= (CW+3)'(count)) begin
            state <= S_CHCMP;
            nch <= '0;
          end else begin
            nch <= (remain > (CW+3)'(dmhq_pkg::ARITY)) ? KW'(dmhq_pkg::ARITY)
                                                        : KW'(remain);
            state <= S_CHRD;
          end
        end
        S_CHRD: begin
          ch <= ch + KW'(1);
          state <= S_CHCMP;
        end
        S_CHCMP: begin
          if (ch == nch) begin
            if (sink_move) begin
              pos <= cand_addr;
              state <= S_LASTW;
            end else begin
              state <= S_OUT;
            end
          end else begin
            ch <= ch + KW'(1);
          end
          if (take) begin
            best_vld <= 1'b1;
            best <= mrd;
            best_addr <= cand_addr;
          end
        end
        S_OUT: begin
          res_count <= count;
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/dary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// dary_min_heap_queue
// 4-ary min-heap priority queue on a single-port-read heap memory
// ----------------------------------------------------------------------------
// Usage: one beat on s_axis is one operation (push or pop); exactly one beat
// comes back on m_axis for it, with status, the popped entry and occupancy.
// Only one operation is held at a time; the next beat is taken the cycle
// after the result has been taken.
// A rejected op answers straight from idle; a push reads and compares the
// parent at each level it moves up; a pop reads the root, then the last
// entry, then at each level visited on the way down reads the children there
// and compares them before it moves down or stops.
// The memory read port sets the pace: at most one entry is read per cycle and
// each compare uses the data read in the cycle before.
// Reset empties the heap at once (the count clears; memory is not swept).
// A stalled m_axis holds the result and s_axis tready stays low.
// ----------------------------------------------------------------------------
module dary_min_heap_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // node_index[15:0], f_key[47:16], g_cost[79:48], parent_index[95:80]
  input  logic [95:0]   s_axis_tdata,
  // mode
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // out_node[15:0], out_key[47:16], out_cost[79:48], out_parent[95:80],
  // occupancy[108:96], zero fill [111:109]
  output logic [111:0]  m_axis_tdata,
  // status
  output logic [1:0]    m_axis_tuser
);

  dmhq_pkg::entry_t              in_entry, res_entry, mrd;
  dmhq_pkg::mem_req_t            mreq;
  logic [dmhq_pkg::CNT_W-1:0]    res_count;

  // unpack input beat
  assign in_entry.node   = s_axis_tdata[15:0];
  assign in_entry.key    = s_axis_tdata[47:16];
  assign in_entry.cost   = s_axis_tdata[79:48];
  assign in_entry.parent = s_axis_tdata[95:80];

  dmhq_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_mode(s_axis_tuser), .in_entry(in_entry),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_status(m_axis_tuser), .res_entry(res_entry), .res_count(res_count),
    .mreq(mreq), .mrd(mrd)
  );

  dmhq_ram u_ram (.clk(clk), .req(mreq), .rd_data(mrd));

  // pack output beat
  assign m_axis_tdata = {3'b000, res_count, res_entry.parent, res_entry.cost,
                         res_entry.key, res_entry.node};

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// push/pop streams into the 4-ary min-heap queue, each result beat checked
// against a behavioral heap kept in step with every accepted operation
// ----------------------------------------------------------------------------
module testbench;

  localparam int STALL_LIMIT = 20000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] node;
    logic [31:0] key;
    logic [31:0] cost;
    logic [15:0] parent;
    logic [12:0] occ;
  } heap_result_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  dmhq_pkg::entry_t heap_mem [dmhq_pkg::CAPACITY];
  int           heap_size;
  heap_result_t pending_results [$];
  int           errors;
  int           idle_cycles;
  bit           hold_off;
  int           hold_cycles;

  dary_min_heap_queue uut (.*);

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // sift the entry at pos toward the root
  function automatic void sift_up(int pos);
    dmhq_pkg::entry_t e;
    int     up;
    e = heap_mem[pos];
    while (pos > 0) begin
      up = (pos - 1) / dmhq_pkg::ARITY;
      if (!(e.key < heap_mem[up].key)) break;
      heap_mem[pos] = heap_mem[up];
      pos = up;
    end
    heap_mem[pos] = e;
  endfunction

  // sift the root down, first smallest child wins ties
  function automatic void sift_down();
    dmhq_pkg::entry_t e;
    int     pos, first, last, best;
    pos = 0;
    e = heap_mem[0];
    forever begin
      first = dmhq_pkg::ARITY * pos + 1;
      if (first >= heap_size) break;
      best = first;
      last = (first + dmhq_pkg::ARITY > heap_size) ? heap_size
                                                    : first + dmhq_pkg::ARITY;
      for (int ch = first + 1; ch < last; ch++)
        if (heap_mem[ch].key < heap_mem[best].key) best = ch;
      if (e.key <= heap_mem[best].key) break;
      heap_mem[pos] = heap_mem[best];
      pos = best;
    end
    heap_mem[pos] = e;
  endfunction

  // expected result of one operation, updating the local heap
  function automatic heap_result_t heap_op(logic op, dmhq_pkg::entry_t e);
    heap_result_t r;
    r = '0;
    if (op == OP_PUSH) begin
      if (heap_size >= dmhq_pkg::CAPACITY) r.status = dmhq_pkg::ST_FULL;
      else begin
        heap_mem[heap_size] = e;
        heap_size++;
        sift_up(heap_size - 1);
      end
    end else begin
      if (heap_size == 0) r.status = dmhq_pkg::ST_EMPTY;
      else begin
        r.node = heap_mem[0].node;
        r.key = heap_mem[0].key;
        r.cost = heap_mem[0].cost;
        r.parent = heap_mem[0].parent;
        heap_size--;
        heap_mem[0] = heap_mem[heap_size];
        if (heap_size > 0) sift_down();
      end
    end
    r.status = (r.status == 2'd0) ? dmhq_pkg::ST_OK : r.status;
    r.occ = heap_size[12:0];
    return r;
  endfunction

  // random gap, mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one operation beat after an optional random gap; valid drops between
  // beats, and the block is busy after each accepted beat anyway
  task automatic send_op(logic op, logic [15:0] node, logic [31:0] key,
                         logic [31:0] cost, logic [15:0] parent, bit gaps = 1);
    dmhq_pkg::entry_t e;
    int     g;
    e = '{node: node, key: key, cost: cost, parent: parent};
    g = gaps ? gap_len() : 0;
    repeat (g + 1) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {parent, cost, key, node};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.insert(pending_results.size(), heap_op(op, e));
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // result beat checker
  always @(posedge clk) begin
    heap_result_t got, exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[47:16],
             m_axis_tdata[79:48], m_axis_tdata[95:80], m_axis_tdata[108:96]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.status !== exp_r.status)
          $display("%0t: status exp %h got %h", $time, exp_r.status, got.status);
        if (got.node !== exp_r.node)
          $display("%0t: node exp %h got %h", $time, exp_r.node, got.node);
        if (got.key !== exp_r.key)
          $display("%0t: key exp %h got %h", $time, exp_r.key, got.key);
        if (got.cost !== exp_r.cost)
          $display("%0t: cost exp %h got %h", $time, exp_r.cost, got.cost);
        if (got.parent !== exp_r.parent)
          $display("%0t: parent exp %h got %h", $time, exp_r.parent, got.parent);
        if (got.occ !== exp_r.occ)
          $display("%0t: occupancy exp %h got %h", $time, exp_r.occ, got.occ);
        if (got !== exp_r) errors++;
      end
    end
  end

  // receiver ready: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if (hold_off) begin
      m_axis_tready <= 1'b0;
      hold_cycles++;
      if (hold_cycles >= 300) begin
        hold_off <= 1'b0;
      end
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < 70) ||
                       ($urandom_range(0, 3) == 0);
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // edge cases: empty pops, extremes, ties
  task automatic test_directed();
    send_op(OP_POP, 16'h0, 32'h0, 32'h0, 16'h0);
    send_op(OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_op(OP_PUSH, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000);
    send_op(OP_PUSH, 16'h1111, 32'h3F80_0000, 32'hA5A5_A5A5, 16'h2222);
    send_op(OP_PUSH, 16'h3333, 32'h3F80_0000, 32'h5A5A_5A5A, 16'h4444);
    send_op(OP_PUSH, 16'h5555, 32'h3F80_0000, 32'h1234_5678, 16'h6666);
    send_op(OP_PUSH, 16'h7777, 32'h4000_0000, 32'h8765_4321, 16'h8888);
    for (int i = 0; i < 8; i++)
      send_op(OP_POP, 16'h0, 32'h0, 32'h0, 16'h0);
  endtask

  // long receiver hold-off while operations keep coming
  task automatic test_backpressure();
    hold_cycles = 0;
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++)
      send_op(OP_PUSH, 16'($urandom), $urandom, $urandom, 16'($urandom), 0);
  endtask

  // random mix, push-heavy then pop-heavy, narrow keys for ties
  task automatic test_random();
    logic [31:0] key;
    logic        op;
    for (int i = 0; i < 430; i++) begin
      op = ($urandom_range(0, 99) < ((i % 150) < 90 ? 30 : 70)) ? OP_POP : OP_PUSH;
      key = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom;
      send_op(op, 16'($urandom), key, $urandom, 16'($urandom));
    end
  endtask

  initial begin
    errors = 0;
    heap_size = 0;
    hold_off = 1'b0;
    hold_cycles = 0;
    idle_cycles = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_PUSH;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    wait_drained();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: dary_min_heap_queue.f
rtl/dmhq_pkg.sv
rtl/dmhq_ram.sv
rtl/dmhq_ctrl.sv
rtl/dary_min_heap_queue.sv
tb/sv/testbench.sv
